[hdl/jdc_pkg.sv]
// Shared widths, calendar constants and month table for the Julian Day converter.
`default_nettype none

package jdc_pkg;

  localparam int IN_W    = 39;
  localparam int YEAR_W  = 16;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int FO_W    = 16;
  localparam int XW      = 9;
  localparam int EW      = 4;

  localparam int GREG_START  = 2299161;
  localparam int ALPHA_OFS   = 7468865;
  localparam int GREG_CYCLE  = 146097;
  localparam int JUL_CYCLE   = 7305;
  localparam int B_OFS       = 1524;
  localparam int C_OFS       = 2442;
  localparam int DAYS_4Y     = 1461;
  localparam int YEAR_LATE   = 4716;
  localparam int YEAR_EARLY  = 4715;
  localparam int E_WRAP      = 14;

  // floor(30.6001 * e)
  function automatic logic [XW-1:0] month_base(input logic [EW-1:0] e);
    logic [XW-1:0] r;
    unique case (e)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      4'd15:   r = 9'd459;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/jdc_if.sv]
// Valid/ready channel interfaces for the timestamp input and the date output.
`default_nettype none

interface jdc_stamp_if
  import jdc_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] julian_time;

  modport source (output valid, output julian_time, input ready);
  modport sink   (input valid, input julian_time, output ready);
endinterface

interface jdc_date_if
  import jdc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [YEAR_W-1:0] year;
  logic [MONTH_W-1:0]       month;
  logic [DAY_W-1:0]         day_whole;
  logic [FO_W-1:0]          day_fraction;

  modport source (output valid, output year, output month, output day_whole,
                  output day_fraction, input ready);
  modport sink   (input valid, input year, input month, input day_whole,
                  input day_fraction, output ready);
endinterface

`default_nettype wire

[hdl/jdc_cdiv.sv]
// Pipelined division by a constant through reciprocal multiplication, with sideband.
`default_nettype none

module jdc_cdiv
  import jdc_pkg::*;
#(
  parameter int NW      = 26,
  parameter int DIVISOR = 146097,
  parameter int SW      = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [NW-1:0] num,
  input  logic [SW-1:0] side_in,
  output logic          vout,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);

  localparam int LW  = $clog2(DIVISOR);
  localparam int KW  = NW + LW;
  localparam int MW  = NW + 1;
  localparam int HW  = (MW + 1) / 2;
  localparam int PHW = NW + MW - HW;
  localparam int PLW = NW + HW;
  localparam int PW  = NW + MW;
  localparam logic [MW-1:0] MUL =
    MW'(((longint'(1) << KW) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR));
  localparam logic [MW-HW-1:0] MUL_HI = MUL[MW-1:HW];
  localparam logic [HW-1:0]    MUL_LO = MUL[HW-1:0];

  logic [PHW-1:0] ph;
  logic [PLW-1:0] pl;
  logic [SW-1:0]  side_a;
  logic           v_a;
  logic [PW-1:0]  full;
  logic [NW-1:0]  q_b;
  logic [SW-1:0]  side_b;
  logic           v_b;

  // stage A: partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (en) begin
      v_a <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph     <= PHW'(num) * PHW'(MUL_HI);
      pl     <= PLW'(num) * PLW'(MUL_LO);
      side_a <= side_in;
    end
  end

  // stage B: sum and scale
  assign full = (PW'(ph) << HW) + PW'(pl);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (en) begin
      v_b <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_b    <= NW'(full[PW-1:KW]);
      side_b <= side_a;
    end
  end

  assign vout     = v_b;
  assign quo      = q_b;
  assign side_out = side_b;

endmodule

`default_nettype wire

[hdl/julian_day_to_calendar_date.sv]
// Julian Day (fixed point) to calendar date converter, Meeus method, fully pipelined.
//
//   port   | role   | payload
//   -------+--------+---------------------------------------------------
//   stamp  | sink   | julian_time[38:0], FRAC_BITS fraction bits
//   date   | source | year (signed), month, day_whole, day_fraction
//
// One transfer per clock unless date stalls. For any FRAC_BITS there are seven
// single stages plus two in each constant divider (partial products, then
// sum and scale).
// rst clears the stage valid bits only; no state besides the pipeline.
// A stall on date freezes every stage, and stamp.ready drops with it.
`default_nettype none

module julian_day_to_calendar_date
  import jdc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  jdc_stamp_if.sink   stamp,
  jdc_date_if.source  date
);

  localparam int ZW    = IN_W + 1 - FRAC_BITS;
  localparam int ZXW   = (ZW > 24) ? ZW : 24;
  localparam int N1W   = ZXW + 2;
  localparam int BW    = ZXW + 1;
  localparam int N2W   = BW + 5;
  localparam int CW    = BW - 7;
  localparam int PW    = CW + 11;
  localparam int S1W   = 1 + ZXW + FO_W;
  localparam int S2W   = BW + FO_W;
  localparam logic [IN_W:0] HALF = (IN_W+1)'(1) << (FRAC_BITS - 1);

  logic adv;
  logic out_v;

  assign adv         = !out_v || date.ready;
  assign stamp.ready = adv;

  // stage 1: add half day, split
  logic [IN_W:0]  sum;
  logic [FO_W-1:0] frac_cut;
  logic            s1_v;
  logic [ZW-1:0]   z1;
  logic [FO_W-1:0] f1;

  assign sum = {1'b0, stamp.julian_time} + HALF;

  if (FRAC_BITS >= FO_W) begin : g_frac_cut
    assign frac_cut = sum[FRAC_BITS-1 -: FO_W];
  end else begin : g_frac_pad
    assign frac_cut = {sum[FRAC_BITS-1:0], {(FO_W - FRAC_BITS){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= stamp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z1 <= sum[IN_W:FRAC_BITS];
      f1 <= frac_cut;
    end
  end

  // stage 2: Gregorian test and alpha numerator
  logic [ZXW-1:0]  zx1;
  logic            g_next;
  logic            s2_v;
  logic [N1W-1:0]  n1;
  logic [S1W-1:0]  side1;

  assign zx1    = ZXW'(z1);
  assign g_next = zx1 >= ZXW'(GREG_START);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1    <= g_next ? ({zx1, 2'b00} - N1W'(ALPHA_OFS)) : '0;
      side1 <= {g_next, zx1, f1};
    end
  end

  logic           d1_v;
  logic [N1W-1:0] alpha;
  logic [S1W-1:0] side1_q;

  jdc_cdiv #(
    .NW(N1W), .DIVISOR(GREG_CYCLE), .SW(S1W)
  ) u_div_alpha (
    .clk(clk), .rst(rst), .en(adv), .vin(s2_v), .num(n1), .side_in(side1),
    .vout(d1_v), .quo(alpha), .side_out(side1_q)
  );

  // stage 3: b = a + 1524
  logic [BW-1:0]  alpha_t;
  logic [BW-1:0]  adj;
  logic           s3_v;
  logic [BW-1:0]  b3;
  logic [FO_W-1:0] f3;

  assign alpha_t = alpha[BW-1:0];
  assign adj     = side1_q[S1W-1] ? (alpha_t + BW'(1) - (alpha_t >> 2)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b3 <= BW'(side1_q[FO_W +: ZXW]) + adj + BW'(B_OFS);
      f3 <= side1_q[FO_W-1:0];
    end
  end

  // stage 4: c numerator 20b - 2442
  logic           s4_v;
  logic [N2W-1:0] n2;
  logic [S2W-1:0] side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n2    <= (N2W'(b3) << 4) + (N2W'(b3) << 2) - N2W'(C_OFS);
      side2 <= {b3, f3};
    end
  end

  logic           d2_v;
  logic [N2W-1:0] cq;
  logic [S2W-1:0] side2_q;

  jdc_cdiv #(
    .NW(N2W), .DIVISOR(JUL_CYCLE), .SW(S2W)
  ) u_div_c (
    .clk(clk), .rst(rst), .en(adv), .vin(s4_v), .num(n2), .side_in(side2),
    .vout(d2_v), .quo(cq), .side_out(side2_q)
  );

  // stage 5: d = floor(1461c / 4)
  logic [CW-1:0]   c4;
  logic [PW-1:0]   prod;
  logic            s5_v;
  logic [BW-1:0]   d5;
  logic [BW-1:0]   b5;
  logic [YEAR_W-1:0] c5;
  logic [FO_W-1:0] f5;

  assign c4   = cq[CW-1:0];
  assign prod = PW'(c4) * PW'(DAYS_4Y);

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (adv) begin
      s5_v <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d5 <= prod[BW+1:2];
      b5 <= side2_q[FO_W +: BW];
      c5 <= c4[YEAR_W-1:0];
      f5 <= side2_q[FO_W-1:0];
    end
  end

  // stage 6: day offset within the March-based year
  logic [BW-1:0]     diff;
  logic              s6_v;
  logic [XW-1:0]     x6;
  logic [YEAR_W-1:0] c6;
  logic [FO_W-1:0]   f6;

  assign diff = b5 - d5;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (adv) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x6 <= diff[XW-1:0];
      c6 <= c5;
      f6 <= f5;
    end
  end

  // stage 7: month index, day, month, year
  logic [EW-1:0]      e7;
  logic [MONTH_W-1:0] month_next;
  logic [DAY_W-1:0]   day_next;
  logic [YEAR_W-1:0]  year_next;
  logic [XW-1:0]      day_wide;
  logic [YEAR_W-1:0]  year_r;
  logic [MONTH_W-1:0] month_r;
  logic [DAY_W-1:0]   day_r;
  logic [FO_W-1:0]    frac_r;

  always_comb begin
    e7 = '0;
    for (int k = 1; k < 16; k++) begin
      if (x6 > month_base(EW'(k))) begin
        e7 = e7 + EW'(1);
      end
    end
    day_wide   = x6 - month_base(e7);
    day_next   = day_wide[DAY_W-1:0];
    month_next = (e7 < EW'(E_WRAP)) ? (e7 - MONTH_W'(1)) : (e7 - MONTH_W'(13));
    year_next  = (month_next > MONTH_W'(2)) ? (c6 - YEAR_W'(YEAR_LATE))
                                            : (c6 - YEAR_W'(YEAR_EARLY));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      year_r  <= year_next;
      month_r <= month_next;
      day_r   <= day_next;
      frac_r  <= f6;
    end
  end

  assign date.valid        = out_v;
  assign date.year         = year_r;
  assign date.month        = month_r;
  assign date.day_whole    = day_r;
  assign date.day_fraction = frac_r;

endmodule

`default_nettype wire

[hdl/jdc_check.sv]
// Port-level assertions for the Julian Day converter, bound to the top level.
`default_nettype none

module jdc_check
  import jdc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [YEAR_W-1:0]  year,
  input logic [MONTH_W-1:0] month,
  input logic [DAY_W-1:0]   day_whole,
  input logic [FO_W-1:0]    day_fraction
);

  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_ready_follows : assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output can drain");

  a_date_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1 && month <= 4'd12 &&
                   day_whole >= 5'd1 && day_whole <= 5'd31))
    else $error("month or day out of range");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(year) && $stable(month) &&
                                   $stable(day_whole) && $stable(day_fraction)))
    else $error("stalled result changed");

endmodule

bind julian_day_to_calendar_date jdc_check u_jdc_check (
  .clk(clk),
  .rst(rst),
  .in_ready(stamp.ready),
  .out_valid(date.valid),
  .out_ready(date.ready),
  .year(date.year),
  .month(date.month),
  .day_whole(date.day_whole),
  .day_fraction(date.day_fraction)
);

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the Julian Day to calendar date converter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jdc_pkg::*;

  localparam int FRAC          = 16;
  localparam int RANDOM_ITEMS  = 700;
  localparam int HOLD_CYCLES   = 120;
  localparam int STALL_ITEMS   = 80;
  localparam int DRAIN_CYCLES  = 40;
  localparam int MAX_REPORTS   = 10;
  localparam longint Y2K_DAY   = 2451545;
  localparam longint Y1900_MAR = 2415080;

  typedef struct packed {
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day_whole;
    logic [FO_W-1:0]          day_fraction;
  } cal_date_t;

  typedef struct {
    logic [IN_W-1:0] stamp;
    cal_date_t       date;
  } date_expect_t;

  logic clk;
  logic rst;

  jdc_stamp_if stamp_if ();
  jdc_date_if  date_if ();

  julian_day_to_calendar_date #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .stamp(stamp_if),
    .date (date_if)
  );

  date_expect_t pending_dates[$];
  int           mismatches;
  bit           no_idle;
  int           sink_hold;

  function automatic cal_date_t predict_date(input logic [IN_W-1:0] t);
    cal_date_t r;
    longint sum, z, frac, alpha, a, b, c, d, e, dd, mm, yy;
    sum  = longint'({25'b0, t}) + (longint'(1) << (FRAC - 1));
    z    = sum >> FRAC;
    frac = sum & ((longint'(1) << FRAC) - 1);
    if (z >= GREG_START) begin
      alpha = (4 * z - ALPHA_OFS) / GREG_CYCLE;
      a     = z + 1 + alpha - alpha / 4;
    end else begin
      a = z;
    end
    b  = a + B_OFS;
    c  = (20 * b - C_OFS) / JUL_CYCLE;
    d  = (DAYS_4Y * c) / 4;
    e  = (10000 * (b - d)) / 306001;
    dd = b - d - (306001 * e) / 10000;
    mm = (e < E_WRAP) ? e - 1 : e - 13;
    yy = (mm > 2) ? c - YEAR_LATE : c - YEAR_EARLY;
    if (FRAC > 16) frac = frac >> (FRAC - 16);
    else           frac = frac << (16 - FRAC);
    r.year         = yy[YEAR_W-1:0];
    r.month        = mm[MONTH_W-1:0];
    r.day_whole    = dd[DAY_W-1:0];
    r.day_fraction = frac[FO_W-1:0];
    return r;
  endfunction

  // stamp whose calendar day is z and whose time since midnight is f
  function automatic logic [IN_W-1:0] stamp_at(input longint z, input longint f);
    logic [IN_W-1:0] r;
    r = IN_W'((z << FRAC) + f - (longint'(1) << (FRAC - 1)));
    return r;
  endfunction

  function automatic int idle_gap();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic report_failure(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ns: %s", $realtime, what);
  endtask

  // entered and left at a falling edge; valid stays high on return
  task automatic send_stamp(input logic [IN_W-1:0] t);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      stamp_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    stamp_if.valid       <= 1'b1;
    stamp_if.julian_time <= t;
    do @(posedge clk); while (!stamp_if.ready);
    pending_dates.push_back('{t, predict_date(t)});
    @(negedge clk);
  endtask

  task automatic wait_drained();
    stamp_if.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_calendar_extremes();
    send_stamp('0);
    send_stamp('1);
    send_stamp(39'h0_0000_7FFF);
  endtask

  task automatic test_half_day_carry();
    send_stamp(39'h0_0000_8000);
    send_stamp(stamp_at(Y2K_DAY, 0) - 1);
    send_stamp(stamp_at(Y2K_DAY, 0));
  endtask

  task automatic test_gregorian_switch();
    send_stamp(stamp_at(GREG_START - 1, 0));
    send_stamp(stamp_at(GREG_START - 1, 16'hFFFF));
    send_stamp(stamp_at(GREG_START, 0));
    send_stamp(stamp_at(GREG_START, 1));
  endtask

  task automatic test_month_boundaries();
    int offs[14];
    offs = '{0, 31, 59, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 365};
    foreach (offs[i]) send_stamp(stamp_at(Y2K_DAY + offs[i], $urandom_range(0, 65535)));
    send_stamp(stamp_at(Y1900_MAR - 1, $urandom_range(0, 65535)));
    send_stamp(stamp_at(Y1900_MAR, $urandom_range(0, 65535)));
  endtask

  task automatic test_input_stall();
    wait_drained();
    no_idle   = 1'b1;
    sink_hold = HOLD_CYCLES;
    repeat (STALL_ITEMS)
      send_stamp(stamp_at($urandom_range(1000000, 2700000), $urandom_range(0, 65535)));
    no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_stamps();
    logic [IN_W-1:0] t;
    int kind;
    int off;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) wait_drained();
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        t = {7'($urandom_range(0, 127)), 32'($urandom())};
      end else if (kind <= 6) begin
        t = stamp_at($urandom_range(1000000, 2700000), $urandom_range(0, 65535));
      end else if (kind == 7) begin
        off = $urandom_range(0, 7);
        t   = stamp_at(GREG_START + off - 4, $urandom_range(0, 65535));
      end else if (kind == 8) begin
        t = IN_W'($urandom_range(0, 32'h03FF_FFFF));
      end else begin
        t = '1;
        t = t - $urandom_range(0, 16777215);
      end
      send_stamp(t);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (sink_hold > 0) begin
        date_if.ready <= 1'b0;
        repeat (sink_hold) @(negedge clk);
        sink_hold = 0;
      end
      gap = idle_gap();
      if (gap > 0) begin
        date_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      date_if.ready <= 1'b1;
      do @(posedge clk); while (!date_if.valid);
      @(negedge clk);
    end
  end

  initial begin
    date_expect_t want;
    cal_date_t    got;
    forever begin
      @(posedge clk);
      if (!rst && date_if.valid && date_if.ready) begin
        got = '{date_if.year, date_if.month, date_if.day_whole, date_if.day_fraction};
        if (pending_dates.size() == 0) begin
          report_failure($sformatf("unexpected date %0d-%0d-%0d frac %h",
                                   $signed(got.year), got.month, got.day_whole,
                                   got.day_fraction));
        end else begin
          want = pending_dates.pop_front();
          if (got.year !== want.date.year || got.month !== want.date.month ||
              got.day_whole !== want.date.day_whole ||
              got.day_fraction !== want.date.day_fraction) begin
            report_failure($sformatf(
              "stamp %h: exp %0d-%0d-%0d frac %h, got %0d-%0d-%0d frac %h",
              want.stamp, $signed(want.date.year), want.date.month,
              want.date.day_whole, want.date.day_fraction, $signed(got.year),
              got.month, got.day_whole, got.day_fraction));
          end
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst                  = 1'b1;
    stamp_if.valid       = 1'b0;
    stamp_if.julian_time = '0;
    date_if.ready        = 1'b0;
    mismatches           = 0;
    no_idle              = 1'b0;
    sink_hold            = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_calendar_extremes();
    test_half_day_carry();
    test_gregorian_switch();
    test_month_boundaries();
    test_input_stall();
    test_random_stamps();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/jdc_pkg.sv
hdl/jdc_if.sv
hdl/jdc_cdiv.sv
hdl/julian_day_to_calendar_date.sv
hdl/jdc_check.sv
sim/tb.sv
